// ----- rtl/asml_pkg.sv -----
package asml_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int COORD_BITS_DEF   = 24;
    localparam logic [7:0] TOL_RESET = 8'd3;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_JOIN = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_EDGE  = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_JOIN  = 3'd4;
    localparam logic [2:0] ST_ENTRY = 3'd5;
    localparam logic [2:0] ST_EMPTY = 3'd6;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WAIT,
        S_ADD_CMP,
        S_ADD_DONE,
        S_J_RDI,
        S_J_WAITI,
        S_J_LATI,
        S_J_RDJ,
        S_J_WAITJ,
        S_J_CMP,
        S_J_SH_RD,
        S_J_SH_WAIT,
        S_J_SH_WR,
        S_J_APPEND,
        S_J_DONE,
        S_RD_RD,
        S_RD_WAIT,
        S_RD_OUT,
        S_EMPTY,
        S_OUT
    } state_t;

endpackage

// ----- rtl/asml_if.sv -----
interface asml_in_if
    import asml_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface asml_out_if
    import asml_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CNT_BITS   = 7
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            status;
    logic                  vertical;
    logic [COORD_BITS-1:0] intercept;
    logic [COORD_BITS-1:0] seg_begin;
    logic [COORD_BITS-1:0] seg_end;
    logic [CNT_BITS-1:0]   entries;
    logic                  last;

    modport source (output valid, status, vertical, intercept, seg_begin, seg_end, entries,
                    last, input ready);
    modport sink   (input valid, status, vertical, intercept, seg_begin, seg_end, entries,
                    last, output ready);
endinterface

interface asml_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/axis_segment_merge_list.sv -----
// Segment list with add, join and readout commands.
// Channels: in (mode plus two end points), out (status words), cfg (tolerance, 8 bits).
// One item is taken at a time; in.ready is low until the item's last word is taken,
//   and rises the cycle after that.
// Add: reads the stored entries in turn through one RAM port and one shared compare unit,
//   stopping at the first close one (duplicate); an edge drop skips the scan.
// Join: pairwise scan that restarts from the first entry after each merge;
//   each merge shifts the tail of the list down twice and appends the merged entry.
//   Worst case grows with the cube of the count.
// Readout: one word per entry, or one empty-status word when the list is empty.
// The single output register holds its word while out.ready is low; the sequencer waits.
// Reset empties the list (count to zero) and sets the tolerance to 3; RAM contents are
// not cleared, since only entries below the count are read.
// Configuration writes are always accepted.
module axis_segment_merge_list
    import asml_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    asml_in_if.sink     in,
    asml_out_if.source  out,
    asml_cfg_if.sink    cfg
);
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SW = 1 + 3 * COORD_BITS;

    typedef logic [COORD_BITS-1:0] crd_t;

    state_t state_reg, state_next;
    logic [7:0]    tol_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic          pass_reg, pass_next;
    logic [SW-1:0] cand_reg, cand_next;
    logic [SW-1:0] a_reg, a_next;
    logic [2:0]    st_reg, st_next;
    logic          ov_reg, ov_next;
    logic [2:0]    o_st_reg, o_st_next;
    logic [SW-1:0] o_seg_reg, o_seg_next;
    logic          o_last_reg, o_last_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [SW-1:0] wdata, rdata;

    asml_ram #(.WIDTH(SW), .DEPTH(MAX_SEGMENTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    function automatic crd_t adiff(crd_t a, crd_t b);
        return (a > b) ? a - b : b - a;
    endfunction

    // shared compare unit: x is one operand, y the other
    logic [SW-1:0] cx, cy;
    logic          c_v_eq, c_ic_ok, c_close, c_j1, c_j2;
    crd_t          x_ic, x_b, x_e, y_ic, y_b, y_e;
    crd_t          tol_c;
    always_comb
    begin
        tol_c = crd_t'(tol_reg);
        {x_ic, x_b, x_e} = cx[SW-2:0];
        {y_ic, y_b, y_e} = cy[SW-2:0];
        c_v_eq  = cx[SW-1] == cy[SW-1];
        c_ic_ok = adiff(x_ic, y_ic) <= tol_c;
        c_close = c_v_eq && c_ic_ok && adiff(x_b, y_b) <= tol_c && adiff(x_e, y_e) <= tol_c;
        c_j1    = c_v_eq && c_ic_ok && adiff(x_e, y_b) < tol_c;
        c_j2    = c_v_eq && c_ic_ok && adiff(y_e, x_b) < tol_c;
    end

    // candidate from input
    logic [SW-1:0] in_seg;
    always_comb
    begin
        if (adiff(in.start_x, in.end_x) < tol_c)
        begin
            in_seg = {1'b1, in.start_x,
                      (in.start_y < in.end_y) ? in.start_y : in.end_y,
                      (in.start_y < in.end_y) ? in.end_y : in.start_y};
        end
        else
        begin
            in_seg = {1'b0, in.start_y,
                      (in.start_x < in.end_x) ? in.start_x : in.end_x,
                      (in.start_x < in.end_x) ? in.end_x : in.start_x};
        end
    end

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg.valid)
        begin
            tol_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        pass_reg   <= pass_next;
        cand_reg   <= cand_next;
        a_reg      <= a_next;
        st_reg     <= st_next;
        o_st_reg   <= o_st_next;
        o_seg_reg  <= o_seg_next;
        o_last_reg <= o_last_next;
    end

    assign in.ready      = state_reg == S_IDLE;
    assign out.valid     = ov_reg;
    assign out.status    = o_st_reg;
    assign out.vertical  = o_seg_reg[SW-1];
    assign out.intercept = o_seg_reg[SW-2 -: COORD_BITS];
    assign out.seg_begin = o_seg_reg[2*COORD_BITS-1 -: COORD_BITS];
    assign out.seg_end   = o_seg_reg[COORD_BITS-1:0];
    assign out.entries   = cnt_reg;
    assign out.last      = o_last_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        pass_next   = pass_reg;
        cand_next   = cand_reg;
        a_next      = a_reg;
        st_next     = st_reg;
        ov_next     = ov_reg;
        o_st_next   = o_st_reg;
        o_seg_next  = o_seg_reg;
        o_last_next = o_last_reg;
        we          = 1'b0;
        waddr       = k_reg[AW-1:0];
        wdata       = rdata;
        raddr       = k_reg[AW-1:0];
        cx          = rdata;
        cy          = cand_reg;

        if (ov_reg && out.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (in.valid)
                begin
                    cand_next = in_seg;
                    unique case (in.mode)
                        MODE_ADD:
                        begin
                            if (in_seg[SW-2 -: COORD_BITS] < tol_c)
                            begin
                                st_next    = ST_EDGE;
                                state_next = S_ADD_DONE;
                            end
                            else
                            begin
                                st_next    = ST_ADDED;
                                state_next = S_ADD_RD;
                            end
                        end
                        MODE_JOIN:
                        begin
                            i_next     = '0;
                            pass_next  = 1'b0;
                            state_next = S_J_RDI;
                        end
                        MODE_READ:
                        begin
                            state_next = (cnt_reg == '0) ? S_EMPTY : S_RD_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                if (k_reg >= cnt_reg)
                begin
                    state_next = S_ADD_DONE;
                end
                else
                begin
                    raddr      = k_reg[AW-1:0];
                    state_next = S_ADD_WAIT;
                end
            end
            S_ADD_WAIT:
            begin
                state_next = S_ADD_CMP;
            end
            S_ADD_CMP:
            begin
                if (c_close)
                begin
                    st_next    = ST_DUP;
                    state_next = S_ADD_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_ADD_RD;
                end
            end
            S_ADD_DONE:
            begin
                if (!ov_reg)
                begin
                    o_st_next   = st_reg;
                    o_seg_next  = cand_reg;
                    o_last_next = 1'b1;
                    if (st_reg == ST_ADDED)
                    begin
                        if (cnt_reg >= CW'(MAX_SEGMENTS))
                        begin
                            o_st_next = ST_FULL;
                        end
                        else
                        begin
                            we       = 1'b1;
                            waddr    = cnt_reg[AW-1:0];
                            wdata    = cand_reg;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    ov_next    = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_J_RDI:
            begin
                if (i_reg + 1'b1 >= cnt_reg || cnt_reg == '0)
                begin
                    state_next = S_J_DONE;
                end
                else
                begin
                    raddr      = i_reg[AW-1:0];
                    j_next     = i_reg + 1'b1;
                    state_next = S_J_WAITI;
                end
            end
            S_J_WAITI:
            begin
                raddr      = i_reg[AW-1:0];
                state_next = S_J_LATI;
            end
            S_J_LATI:
            begin
                a_next     = rdata;
                state_next = S_J_RDJ;
            end
            S_J_RDJ:
            begin
                if (j_reg >= cnt_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_J_RDI;
                end
                else
                begin
                    raddr      = j_reg[AW-1:0];
                    state_next = S_J_WAITJ;
                end
            end
            S_J_WAITJ:
            begin
                raddr      = j_reg[AW-1:0];
                state_next = S_J_CMP;
            end
            S_J_CMP:
            begin
                cx = a_reg;
                cy = rdata;
                if (c_close)
                begin
                    cand_next = a_reg;
                end
                else if (c_j1)
                begin
                    cand_next = {a_reg[SW-1:COORD_BITS], rdata[COORD_BITS-1:0]};
                end
                else
                begin
                    cand_next = {rdata[SW-1:COORD_BITS], a_reg[COORD_BITS-1:0]};
                end
                if (c_close || c_j1 || c_j2)
                begin
                    // remove j first, then i
                    k_next     = j_reg;
                    pass_next  = 1'b0;
                    state_next = S_J_SH_RD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_J_RDJ;
                end
            end
            S_J_SH_RD:
            begin
                if (k_reg + 1'b1 >= cnt_reg)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (pass_reg)
                    begin
                        state_next = S_J_APPEND;
                    end
                    else
                    begin
                        pass_next  = 1'b1;
                        k_next     = i_reg;
                        state_next = S_J_SH_RD;
                    end
                end
                else
                begin
                    raddr      = AW'(k_reg + 1'b1);
                    state_next = S_J_SH_WAIT;
                end
            end
            S_J_SH_WAIT:
            begin
                raddr      = AW'(k_reg + 1'b1);
                state_next = S_J_SH_WR;
            end
            S_J_SH_WR:
            begin
                we         = 1'b1;
                waddr      = k_reg[AW-1:0];
                wdata      = rdata;
                k_next     = k_reg + 1'b1;
                state_next = S_J_SH_RD;
            end
            S_J_APPEND:
            begin
                we         = 1'b1;
                waddr      = cnt_reg[AW-1:0];
                wdata      = cand_reg;
                cnt_next   = cnt_reg + 1'b1;
                i_next     = '0;
                state_next = S_J_RDI;
            end
            S_J_DONE:
            begin
                if (!ov_reg)
                begin
                    o_st_next   = ST_JOIN;
                    o_seg_next  = '0;
                    o_last_next = 1'b1;
                    ov_next     = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_RD_RD:
            begin
                raddr      = k_reg[AW-1:0];
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (!ov_reg)
                begin
                    o_st_next   = ST_ENTRY;
                    o_seg_next  = rdata;
                    o_last_next = (k_reg + 1'b1) == cnt_reg;
                    ov_next     = 1'b1;
                    k_next      = k_reg + 1'b1;
                    state_next  = ((k_reg + 1'b1) == cnt_reg) ? S_OUT : S_RD_RD;
                end
            end
            S_EMPTY:
            begin
                if (!ov_reg)
                begin
                    o_st_next   = ST_EMPTY;
                    o_seg_next  = '0;
                    o_last_next = 1'b1;
                    ov_next     = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait for the final word to drain
                if (!ov_reg || out.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_SEGMENTS)) else $error("segment count overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(out.status))
        else $error("output word changed under stall");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in.ready |-> !out.valid || out.last) else $error("ready during a readout");
endmodule

// ----- rtl/asml_ram.sv -----
module asml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- dv/asml_tb_pkg.sv -----
`timescale 1ns / 1ps
package asml_tb_pkg;
    import asml_pkg::*;

    typedef struct packed {
        logic        vertical;
        logic [23:0] intercept;
        logic [23:0] seg_begin;
        logic [23:0] seg_end;
    } seg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        vertical;
        logic [23:0] intercept;
        logic [23:0] seg_begin;
        logic [23:0] seg_end;
        logic [6:0]  entries;
        logic        last;
    } word_t;

    class segment_list_scoreboard;
        seg_t        list[$];
        logic [7:0]  tol = TOL_RESET;
        word_t       pending[$];
        int          errors = 0;
        int          words_seen = 0;
        int          merges = 0;

        function logic [23:0] adiff(logic [23:0] a, logic [23:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function bit close(seg_t a, seg_t b);
            return a.vertical == b.vertical && adiff(a.intercept, b.intercept) <= tol &&
                adiff(a.seg_begin, b.seg_begin) <= tol && adiff(a.seg_end, b.seg_end) <= tol;
        endfunction

        function bit joinable(seg_t a, seg_t b, output seg_t r);
            r = a;
            if (close(a, b)) return 1;
            if (a.vertical != b.vertical || adiff(a.intercept, b.intercept) > tol) return 0;
            if (adiff(a.seg_end, b.seg_begin) < tol)
            begin
                r.seg_end = b.seg_end;
                return 1;
            end
            if (adiff(b.seg_end, a.seg_begin) < tol)
            begin
                r = b;
                r.seg_end = a.seg_end;
                return 1;
            end
            return 0;
        endfunction

        function void push(logic [2:0] st, seg_t s, bit lst);
            word_t w;
            w.status = st;
            w.vertical = s.vertical;
            w.intercept = s.intercept;
            w.seg_begin = s.seg_begin;
            w.seg_end = s.seg_end;
            w.entries = 7'(list.size());
            w.last = lst;
            pending.insert(pending.size(), w);
        endfunction

        function void note_item(logic [1:0] mode, logic [23:0] sx, logic [23:0] sy,
                                logic [23:0] ex, logic [23:0] ey);
            seg_t s, r, zero;
            logic [2:0] st;
            bit found;
            zero = '0;
            if (mode == MODE_ADD)
            begin
                if (adiff(sx, ex) < tol)
                begin
                    s.vertical = 1; s.intercept = sx;
                    s.seg_begin = (sy < ey) ? sy : ey; s.seg_end = (sy < ey) ? ey : sy;
                end
                else
                begin
                    s.vertical = 0; s.intercept = sy;
                    s.seg_begin = (sx < ex) ? sx : ex; s.seg_end = (sx < ex) ? ex : sx;
                end
                st = ST_ADDED;
                if (s.intercept < tol) st = ST_EDGE;
                else
                begin
                    foreach (list[k])
                        if (close(list[k], s)) st = ST_DUP;
                    if (st == ST_ADDED)
                    begin
                        if (list.size() >= MAX_SEGMENTS_DEF) st = ST_FULL;
                        else list.insert(list.size(), s);
                    end
                end
                push(st, s, 1);
            end
            else if (mode == MODE_JOIN)
            begin
                found = 1;
                while (found)
                begin
                    found = 0;
                    for (int i = 0; i < list.size() && !found; i++)
                        for (int j = i + 1; j < list.size() && !found; j++)
                            if (joinable(list[i], list[j], r))
                            begin
                                list.delete(j);
                                list.delete(i);
                                list.insert(list.size(), r);
                                found = 1;
                                merges++;
                            end
                end
                push(ST_JOIN, zero, 1);
            end
            else if (mode == MODE_READ)
            begin
                if (list.size() == 0) push(ST_EMPTY, zero, 1);
                foreach (list[k])
                    push(ST_ENTRY, list[k], k == list.size() - 1);
            end
        endfunction

        function void check_word(word_t got);
            word_t e;
            words_seen++;
            if (pending.size() == 0)
            begin
                $error("unexpected word status=%0d", got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin $error("status exp %0d got %0d", e.status, got.status); errors++; end
            if (got.vertical !== e.vertical)
            begin $error("vertical exp %0d got %0d", e.vertical, got.vertical); errors++; end
            if (got.intercept !== e.intercept)
            begin $error("intercept exp %0h got %0h", e.intercept, got.intercept); errors++; end
            if (got.seg_begin !== e.seg_begin)
            begin $error("seg_begin exp %0h got %0h", e.seg_begin, got.seg_begin); errors++; end
            if (got.seg_end !== e.seg_end)
            begin $error("seg_end exp %0h got %0h", e.seg_end, got.seg_end); errors++; end
            if (got.entries !== e.entries)
            begin $error("entries exp %0d got %0d", e.entries, got.entries); errors++; end
            if (got.last !== e.last)
            begin $error("last exp %0d got %0d", e.last, got.last); errors++; end
        endfunction
    endclass
endpackage

// ----- dv/axis_segment_merge_list_test.sv -----
`timescale 1ns / 1ps
module axis_segment_merge_list_test;
    import asml_pkg::*;
    import asml_tb_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    asml_in_if  in_ch();
    asml_out_if out_ch();
    asml_cfg_if cfg_ch();

    axis_segment_merge_list DUT (
        .clk(clk), .rst_n(rst_n), .in(in_ch.sink), .out(out_ch.source), .cfg(cfg_ch.sink)
    );

    segment_list_scoreboard board = new();
    int  hold_cycles = 0;
    int  gap_left = 0;
    int  burst_left = 0;
    logic [23:0] anchor_x, anchor_y;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: own stall pattern, plus a long hold-off when asked
    initial
    begin
        int phase;
        out_ch.ready = 0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 0;
                hold_cycles--;
            end
            else if ((phase / 200) % 3 == 0)
                out_ch.ready <= 1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            w.status = out_ch.status; w.vertical = out_ch.vertical;
            w.intercept = out_ch.intercept; w.seg_begin = out_ch.seg_begin;
            w.seg_end = out_ch.seg_end; w.entries = out_ch.entries; w.last = out_ch.last;
            board.check_word(w);
        end
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_item(in_ch.mode, in_ch.start_x, in_ch.start_y,
                            in_ch.end_x, in_ch.end_y);
    end

    task automatic send_item(logic [1:0] m, logic [23:0] sx, logic [23:0] sy,
                             logic [23:0] ex, logic [23:0] ey, bit paced);
        // step past the edge where the previous word dropped valid
        @(negedge clk);
        if (paced)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end
            repeat (gap_left) @(negedge clk);
            gap_left = 0;
            burst_left--;
        end
        in_ch.valid <= 1;
        in_ch.mode <= m;
        in_ch.start_x <= sx; in_ch.start_y <= sy; in_ch.end_x <= ex; in_ch.end_y <= ey;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid <= 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_tolerance(logic [7:0] t);
        drain();
        // extra idle margin before the tolerance changes
        repeat (2000) @(negedge clk);
        cfg_ch.valid <= 1;
        cfg_ch.data <= t;
        do @(posedge clk); while (!cfg_ch.ready);
        board.tol = t;
        @(negedge clk);
        cfg_ch.valid <= 0;
    endtask

    function automatic logic [23:0] near(logic [23:0] v, int spread);
        return 24'(v + $urandom_range(0, spread));
    endfunction

    // mostly small lists in a narrow window so that duplicates and joins happen
    task automatic random_phase(int count);
        int c;
        logic [23:0] x0, y0, x1, y1;
        for (int n = 0; n < count; n++)
        begin
            c = $urandom_range(0, 99);
            if (c < 6)
                send_item(MODE_JOIN, 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 1);
            else if (c < 12)
                send_item(MODE_READ, 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 1);
            else if (c < 14)
                send_item(MODE_NONE, 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 1);
            else if (c < 22)
                send_item(MODE_ADD, 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 1);
            else
            begin
                x0 = near(anchor_x, 40); y0 = near(anchor_y, 40);
                if ($urandom_range(0, 1))
                begin
                    x1 = near(x0, 4); y1 = near(anchor_y, 40);
                end
                else
                begin
                    y1 = y0; x1 = near(anchor_x, 40);
                end
                send_item(MODE_ADD, x0, y0, x1, y1, 1);
            end
            if (board.list.size() > 40)
                send_item(MODE_JOIN, 0, 0, 0, 0, 1);
        end
    endtask

    initial
    begin
        in_ch.valid = 0; in_ch.mode = MODE_ADD;
        in_ch.start_x = 0; in_ch.start_y = 0; in_ch.end_x = 0; in_ch.end_y = 0;
        cfg_ch.valid = 0; cfg_ch.data = 0;
        anchor_x = 24'h000100; anchor_y = 24'h000100;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty readout, extremes, edge drop, duplicate, joins, ignored mode
        send_item(MODE_READ, 0, 0, 0, 0, 0);
        send_item(MODE_JOIN, 0, 0, 0, 0, 0);
        send_item(MODE_ADD, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 0);
        send_item(MODE_ADD, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0);
        send_item(MODE_ADD, 24'h000002, 24'h000010, 24'h000002, 24'h000020, 0);
        send_item(MODE_ADD, 24'h000500, 24'h000001, 24'h000900, 24'h000001, 0);
        send_item(MODE_ADD, 24'h000100, 24'h000300, 24'h000101, 24'h000200, 0);
        send_item(MODE_ADD, 24'h000101, 24'h000201, 24'h000100, 24'h000302, 0);
        send_item(MODE_ADD, 24'h000100, 24'h000301, 24'h000100, 24'h000400, 0);
        send_item(MODE_ADD, 24'h000800, 24'h000600, 24'h000700, 24'h000600, 0);
        send_item(MODE_ADD, 24'h000900, 24'h000601, 24'h000801, 24'h000601, 0);
        send_item(MODE_ADD, 24'h000650, 24'h000602, 24'h000500, 24'h000602, 0);
        send_item(MODE_NONE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0);
        send_item(MODE_JOIN, 0, 0, 0, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0);

        // fill the list to overflow, holding the receiver off meanwhile
        hold_cycles = 3000;
        for (int k = 0; k < 66; k++)
            send_item(MODE_ADD, 24'(24'h010000 + k * 24'h100), 24'(24'h020000 + k * 24'h100),
                      24'(24'h010000 + k * 24'h100), 24'(24'h020050 + k * 24'h100), 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0);
        drain();
        send_item(MODE_JOIN, 0, 0, 0, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0);

        set_tolerance(8'd0);
        random_phase(70);
        set_tolerance(8'd255);
        random_phase(80);
        set_tolerance(8'd16);
        random_phase(80);
        drain();
        hold_cycles = 2500;
        random_phase(60);
        set_tolerance(8'd1);
        random_phase(50);
        set_tolerance(8'd3);
        random_phase(40);
        send_item(MODE_READ, 0, 0, 0, 0, 0);

        drain();
        repeat (2000) @(negedge clk);
        $display("Covered all modes, %0d merges, tolerance 0..255; %0d result words checked.",
                 board.merges, board.words_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/asml_pkg.sv
rtl/asml_if.sv
rtl/asml_ram.sv
rtl/axis_segment_merge_list.sv
dv/asml_tb_pkg.sv
dv/axis_segment_merge_list_test.sv
